### src/tfwc_pkg.sv
// Shared types and constants of the timestamp frame window cache.
`default_nettype none

package tfwc_pkg;

    // Command field codes
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_MARK   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ORDER = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam int COUNT_BITS     = 7;
    localparam int EVICT_MIN_HELD = 2;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_LOOKUP,
        OP_CLEAR,
        OP_MARK
    } op_t;

    // Front to back: head of the command queue
    typedef struct packed {
        logic valid;
        op_t  op;
    } cmd_ctl_t;

endpackage

`default_nettype wire

### src/tfwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tfwc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### src/tfwc_front.sv
// Input side: accepts command words, decodes the command and queues them.
`default_nettype none

module tfwc_front #(
    parameter int STAMP_BITS  = 48,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_command,
    input  wire logic [STAMP_BITS-1:0]  s_item_ts,
    input  wire logic [HANDLE_BITS-1:0] s_frame_handle,
    input  wire logic [STAMP_BITS-1:0]  s_guard_ts,
    output tfwc_pkg::cmd_ctl_t          q_ctl,
    output logic      [STAMP_BITS-1:0]  q_item_ts,
    output logic      [HANDLE_BITS-1:0] q_frame_handle,
    output logic      [STAMP_BITS-1:0]  q_guard_ts,
    input  wire logic                   q_ready
);

    localparam int DEPTH = tfwc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    tfwc_pkg::op_t          op_reg     [DEPTH];
    logic [STAMP_BITS-1:0]  ts_reg     [DEPTH];
    logic [HANDLE_BITS-1:0] handle_reg [DEPTH];
    logic [STAMP_BITS-1:0]  guard_reg  [DEPTH];

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    tfwc_pkg::op_t in_op;
    logic          push;
    logic          pop;

    always_comb begin
        unique case (s_command)
            tfwc_pkg::CMD_APPEND: in_op = tfwc_pkg::OP_APPEND;
            tfwc_pkg::CMD_LOOKUP: in_op = tfwc_pkg::OP_LOOKUP;
            tfwc_pkg::CMD_CLEAR:  in_op = tfwc_pkg::OP_CLEAR;
            default:              in_op = tfwc_pkg::OP_MARK;
        endcase
    end

    assign s_ready = (fill_reg != FILL_W'(DEPTH));
    assign push    = s_valid && s_ready;
    assign pop     = q_ctl.valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            op_reg[wr_ptr_reg]     <= in_op;
            ts_reg[wr_ptr_reg]     <= s_item_ts;
            handle_reg[wr_ptr_reg] <= s_frame_handle;
            guard_reg[wr_ptr_reg]  <= s_guard_ts;
        end
    end

    assign q_ctl.valid    = (fill_reg != '0);
    assign q_ctl.op       = op_reg[rd_ptr_reg];
    assign q_item_ts      = ts_reg[rd_ptr_reg];
    assign q_frame_handle = handle_reg[rd_ptr_reg];
    assign q_guard_ts     = guard_reg[rd_ptr_reg];

endmodule

`default_nettype wire

### src/tfwc_back.sv
// Execution side: window ring, command sequencer and result register.
`default_nettype none

module tfwc_back #(
    parameter int CAPACITY    = 64,
    parameter int STAMP_BITS  = 48,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [STAMP_BITS-1:0]  cfg_wr_data,
    input  wire tfwc_pkg::cmd_ctl_t     q_ctl,
    input  wire logic [STAMP_BITS-1:0]  q_item_ts,
    input  wire logic [HANDLE_BITS-1:0] q_frame_handle,
    input  wire logic [STAMP_BITS-1:0]  q_guard_ts,
    output logic                        q_ready,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic      [1:0]             m_status,
    output logic      [HANDLE_BITS-1:0] m_found_handle,
    output logic      [STAMP_BITS-1:0]  m_found_ts,
    output logic      [STAMP_BITS-1:0]  m_oldest_ts,
    output logic      [STAMP_BITS-1:0]  m_newest_ts,
    output logic      [tfwc_pkg::COUNT_BITS-1:0] m_held_count,
    output logic                        m_end_marked
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int SUM_W  = IDX_W + 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WORD_W = STAMP_BITS + HANDLE_BITS;
    localparam int CB     = tfwc_pkg::COUNT_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SECOND,
        S_WRITE,
        S_LOOK
    } state_t;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   ended_reg, ended_next;
    logic [STAMP_BITS-1:0]  oldest_reg, oldest_next;
    logic [STAMP_BITS-1:0]  newest_reg, newest_next;
    logic [STAMP_BITS-1:0]  max_span_reg;

    tfwc_pkg::op_t          op_reg, op_next;
    logic [STAMP_BITS-1:0]  ts_reg, ts_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [STAMP_BITS-1:0]  guard_reg, guard_next;

    // lookup walk: next offset to read, reads left, read in flight, it is the last
    logic [IDX_W-1:0]       iss_k_reg, iss_k_next;
    logic                   more_reg, more_next;
    logic                   pend_reg, pend_next;
    logic                   last_reg, last_next;

    logic                   m_valid_reg, m_valid_next;
    logic [1:0]             m_status_reg, m_status_next;
    logic [HANDLE_BITS-1:0] m_found_handle_reg, m_found_handle_next;
    logic [STAMP_BITS-1:0]  m_found_ts_reg, m_found_ts_next;
    logic [STAMP_BITS-1:0]  m_oldest_ts_reg, m_oldest_ts_next;
    logic [STAMP_BITS-1:0]  m_newest_ts_reg, m_newest_ts_next;
    logic [CB-1:0]          m_held_count_reg, m_held_count_next;
    logic                   m_end_marked_reg, m_end_marked_next;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [WORD_W-1:0]      rd_word;
    logic [STAMP_BITS-1:0]  rd_stamp;
    logic [HANDLE_BITS-1:0] rd_handle;

    logic                   done;
    logic [1:0]             st;
    logic [HANDLE_BITS-1:0] f_handle;
    logic [STAMP_BITS-1:0]  f_ts;
    logic                   full;
    logic                   many;
    logic                   span_over;
    logic [CNT_W+CB-1:0]    count_wide;

    tfwc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({ts_reg, handle_reg}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_stamp  = rd_word[WORD_W-1:HANDLE_BITS];
    assign rd_handle = rd_word[HANDLE_BITS-1:0];

    assign full      = (count_reg >= CNT_W'(CAPACITY));
    assign many      = (count_reg > CNT_W'(tfwc_pkg::EVICT_MIN_HELD));
    assign span_over = ((newest_reg - oldest_reg) > max_span_reg);

    // result slot is free now or drains this cycle
    assign q_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        ended_next  = ended_reg;
        oldest_next = oldest_reg;
        newest_next = newest_reg;
        op_next     = op_reg;
        ts_next     = ts_reg;
        handle_next = handle_reg;
        guard_next  = guard_reg;
        iss_k_next  = iss_k_reg;
        more_next   = more_reg;
        pend_next   = pend_reg;
        last_next   = last_reg;

        wr_en    = 1'b0;
        wr_addr  = slot_of(head_reg, count_reg[IDX_W-1:0]);
        rd_en    = 1'b0;
        rd_addr  = slot_of(head_reg, IDX_W'(1));
        done     = 1'b0;
        st       = tfwc_pkg::ST_OK;
        f_handle = '0;
        f_ts     = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (q_ctl.valid && q_ready) begin
                    op_next     = q_ctl.op;
                    ts_next     = q_item_ts;
                    handle_next = q_frame_handle;
                    guard_next  = q_guard_ts;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (op_reg)
                    tfwc_pkg::OP_APPEND: begin
                        if (count_reg == '0) begin
                            wr_en       = 1'b1;
                            wr_addr     = '0;
                            head_next   = '0;
                            count_next  = CNT_W'(1);
                            oldest_next = ts_reg;
                            newest_next = ts_reg;
                            ended_next  = 1'b0;
                            done        = 1'b1;
                        end else if (ts_reg <= newest_reg) begin
                            st   = tfwc_pkg::ST_ORDER;
                            done = 1'b1;
                        end else if (many && span_over) begin
                            // fetch the second entry for the guard check
                            rd_en      = 1'b1;
                            state_next = S_SECOND;
                        end else if (full) begin
                            st   = tfwc_pkg::ST_FULL;
                            done = 1'b1;
                        end else begin
                            state_next = S_WRITE;
                        end
                    end
                    tfwc_pkg::OP_LOOKUP: begin
                        if (count_reg == '0 || (ts_reg > newest_reg && !ended_reg)) begin
                            st   = tfwc_pkg::ST_RANGE;
                            done = 1'b1;
                        end else begin
                            iss_k_next = IDX_W'(count_reg - CNT_W'(1));
                            more_next  = 1'b1;
                            pend_next  = 1'b0;
                            last_next  = 1'b0;
                            state_next = S_LOOK;
                        end
                    end
                    tfwc_pkg::OP_CLEAR: begin
                        head_next  = '0;
                        count_next = '0;
                        ended_next = 1'b0;
                        done       = 1'b1;
                    end
                    default: begin
                        ended_next = 1'b1;
                        done       = 1'b1;
                    end
                endcase
            end
            S_SECOND: begin
                if (rd_stamp <= guard_reg) begin
                    head_next   = slot_of(head_reg, IDX_W'(1));
                    count_next  = count_reg - CNT_W'(1);
                    oldest_next = rd_stamp;
                    state_next  = S_WRITE;
                end else if (full) begin
                    st   = tfwc_pkg::ST_FULL;
                    done = 1'b1;
                end else begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                wr_en       = 1'b1;
                count_next  = count_reg + CNT_W'(1);
                newest_next = ts_reg;
                ended_next  = 1'b0;
                done        = 1'b1;
            end
            S_LOOK: begin
                // one read issued per cycle, newest first; data checked in the cycle after the read
                if (pend_reg && rd_stamp <= ts_reg) begin
                    f_handle = rd_handle;
                    f_ts     = rd_stamp;
                    done     = 1'b1;
                end else if (pend_reg && last_reg) begin
                    st   = tfwc_pkg::ST_RANGE;
                    done = 1'b1;
                end else if (more_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = slot_of(head_reg, iss_k_reg);
                    iss_k_next = iss_k_reg - IDX_W'(1);
                    last_next  = (iss_k_reg == '0);
                    more_next  = (iss_k_reg != '0);
                    pend_next  = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next        = m_valid_reg && !m_ready;
        m_status_next       = m_status_reg;
        m_found_handle_next = m_found_handle_reg;
        m_found_ts_next     = m_found_ts_reg;
        m_oldest_ts_next    = m_oldest_ts_reg;
        m_newest_ts_next    = m_newest_ts_reg;
        m_held_count_next   = m_held_count_reg;
        m_end_marked_next   = m_end_marked_reg;
        count_wide          = {{CB{1'b0}}, count_next};
        if (done) begin
            state_next          = S_IDLE;
            m_valid_next        = 1'b1;
            m_status_next       = st;
            m_found_handle_next = f_handle;
            m_found_ts_next     = f_ts;
            m_oldest_ts_next    = (count_next != '0) ? oldest_next : '0;
            m_newest_ts_next    = (count_next != '0) ? newest_next : '0;
            m_held_count_next   = count_wide[CB-1:0];
            m_end_marked_next   = ended_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            ended_reg    <= 1'b0;
            max_span_reg <= '0;
            more_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            last_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            ended_reg   <= ended_next;
            more_reg    <= more_next;
            pend_reg    <= pend_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                max_span_reg <= cfg_wr_data;
            end
        end
        oldest_reg         <= oldest_next;
        newest_reg         <= newest_next;
        op_reg             <= op_next;
        ts_reg             <= ts_next;
        handle_reg         <= handle_next;
        guard_reg          <= guard_next;
        iss_k_reg          <= iss_k_next;
        m_status_reg       <= m_status_next;
        m_found_handle_reg <= m_found_handle_next;
        m_found_ts_reg     <= m_found_ts_next;
        m_oldest_ts_reg    <= m_oldest_ts_next;
        m_newest_ts_reg    <= m_newest_ts_next;
        m_held_count_reg   <= m_held_count_next;
        m_end_marked_reg   <= m_end_marked_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_found_handle = m_found_handle_reg;
    assign m_found_ts     = m_found_ts_reg;
    assign m_oldest_ts    = m_oldest_ts_reg;
    assign m_newest_ts    = m_newest_ts_reg;
    assign m_held_count   = m_held_count_reg;
    assign m_end_marked   = m_end_marked_reg;

endmodule

`default_nettype wire

### src/timestamp_frame_window_cache.sv
// Top level of the timestamp frame window cache.
//
// Holds up to CAPACITY (timestamp, frame handle) pairs in a ring, oldest to
// newest. Commands come in on the s_ channel (valid/ready): append, lookup,
// clear and mark end of stream. Every command word yields exactly one result
// word on the m_ channel (valid/ready) with status, the matched frame of a
// lookup, the oldest and newest held timestamps, the held count and the
// end-of-stream flag. max_span is written through cfg_wr_en / cfg_wr_data.
// A two-word command queue sits in front of the executing sequencer, and the
// result sits in an output register, so commands are taken while a result
// waits. A stalled m_ready holds the result and backs up the queue.
// The sequencer takes a word from the queue head only while idle. An append
// may read the second entry from the ring RAM for the eviction check, and a
// lookup walks the window backward, newest first, through the one read port
// of the ring RAM, which the walk issues one entry per cycle.
// Reset (aresetn low, synchronous) empties the window, clears the flag and
// max_span and drops queued words; the ring RAM itself is not cleared.
`default_nettype none

module timestamp_frame_window_cache #(
    parameter int CAPACITY    = 64,
    parameter int STAMP_BITS  = 48,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [STAMP_BITS-1:0]  cfg_wr_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_command,
    input  wire logic [STAMP_BITS-1:0]  s_item_ts,
    input  wire logic [HANDLE_BITS-1:0] s_frame_handle,
    input  wire logic [STAMP_BITS-1:0]  s_guard_ts,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic      [1:0]             m_status,
    output logic      [HANDLE_BITS-1:0] m_found_handle,
    output logic      [STAMP_BITS-1:0]  m_found_ts,
    output logic      [STAMP_BITS-1:0]  m_oldest_ts,
    output logic      [STAMP_BITS-1:0]  m_newest_ts,
    output logic      [tfwc_pkg::COUNT_BITS-1:0] m_held_count,
    output logic                        m_end_marked
);

    tfwc_pkg::cmd_ctl_t     q_ctl;
    logic [STAMP_BITS-1:0]  q_item_ts;
    logic [HANDLE_BITS-1:0] q_frame_handle;
    logic [STAMP_BITS-1:0]  q_guard_ts;
    logic                   q_ready;

    tfwc_front #(
        .STAMP_BITS  (STAMP_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_item_ts      (s_item_ts),
        .s_frame_handle (s_frame_handle),
        .s_guard_ts     (s_guard_ts),
        .q_ctl          (q_ctl),
        .q_item_ts      (q_item_ts),
        .q_frame_handle (q_frame_handle),
        .q_guard_ts     (q_guard_ts),
        .q_ready        (q_ready)
    );

    tfwc_back #(
        .CAPACITY    (CAPACITY),
        .STAMP_BITS  (STAMP_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .q_ctl          (q_ctl),
        .q_item_ts      (q_item_ts),
        .q_frame_handle (q_frame_handle),
        .q_guard_ts     (q_guard_ts),
        .q_ready        (q_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_found_handle (m_found_handle),
        .m_found_ts     (m_found_ts),
        .m_oldest_ts    (m_oldest_ts),
        .m_newest_ts    (m_newest_ts),
        .m_held_count   (m_held_count),
        .m_end_marked   (m_end_marked)
    );

endmodule

`default_nettype wire

### src/tfwc_checker.sv
// Port-level checks on the result channel of the window cache, bound to the top.
`default_nettype none

module tfwc_checker #(
    parameter int CAPACITY    = 64,
    parameter int STAMP_BITS  = 48,
    parameter int HANDLE_BITS = 16
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic [1:0]             m_status,
    input wire logic [HANDLE_BITS-1:0] m_found_handle,
    input wire logic [STAMP_BITS-1:0]  m_found_ts,
    input wire logic [STAMP_BITS-1:0]  m_oldest_ts,
    input wire logic [STAMP_BITS-1:0]  m_newest_ts,
    input wire logic [tfwc_pkg::COUNT_BITS-1:0] m_held_count
);

    // stalled result word holds its status, found stamp and held count
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_found_ts)
            && $stable(m_held_count))
        else $error("result word changed while stalled");

    // window is ordered oldest to newest
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_oldest_ts <= m_newest_ts)
        else $error("oldest timestamp above newest");

    // only a successful lookup reports a matched frame
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != tfwc_pkg::ST_OK |-> m_found_ts == '0 && m_found_handle == '0)
        else $error("matched frame on a failed command");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_held_count == '0 && CAPACITY < 128
            |-> m_oldest_ts == '0 && m_newest_ts == '0)
        else $error("empty window reports timestamps");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind timestamp_frame_window_cache tfwc_checker #(
    .CAPACITY    (CAPACITY),
    .STAMP_BITS  (STAMP_BITS),
    .HANDLE_BITS (HANDLE_BITS)
) u_tfwc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_found_handle (m_found_handle),
    .m_found_ts     (m_found_ts),
    .m_oldest_ts    (m_oldest_ts),
    .m_newest_ts    (m_newest_ts),
    .m_held_count   (m_held_count)
);

`default_nettype wire

### bench/tb_timestamp_frame_window_cache.sv
// Self-checking bench for the timestamp frame window cache.
`timescale 1ns / 100ps

module tb_timestamp_frame_window_cache;

    localparam int WIN_DEPTH = 64;
    localparam int TS_W = 48;
    localparam int HDL_W = 16;
    localparam int CNT_W = tfwc_pkg::COUNT_BITS;
    localparam logic [TS_W-1:0] TS_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 100;
    localparam int PHASE_WORDS = 300;

    typedef struct packed {
        logic [1:0]       command;
        logic [TS_W-1:0]  item_ts;
        logic [HDL_W-1:0] frame_handle;
        logic [TS_W-1:0]  guard_ts;
    } frame_cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [HDL_W-1:0] found_handle;
        logic [TS_W-1:0]  found_ts;
        logic [TS_W-1:0]  oldest_ts;
        logic [TS_W-1:0]  newest_ts;
        logic [CNT_W-1:0] held_count;
        logic             end_marked;
    } frame_result_t;

    // pinned rows carry a hand-written result, the rest use the predictor
    typedef struct packed {
        frame_cmd_t    w;
        logic          pinned;
        frame_result_t res;
    } dir_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [TS_W-1:0]   cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_command = tfwc_pkg::CMD_LOOKUP;
    logic [TS_W-1:0]   s_item_ts = '0;
    logic [HDL_W-1:0]  s_frame_handle = '0;
    logic [TS_W-1:0]   s_guard_ts = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_status;
    logic [HDL_W-1:0]  m_found_handle;
    logic [TS_W-1:0]   m_found_ts;
    logic [TS_W-1:0]   m_oldest_ts;
    logic [TS_W-1:0]   m_newest_ts;
    logic [CNT_W-1:0]  m_held_count;
    logic              m_end_marked;

    timestamp_frame_window_cache #(
        .CAPACITY(WIN_DEPTH),
        .STAMP_BITS(TS_W),
        .HANDLE_BITS(HDL_W)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_item_ts(s_item_ts),
        .s_frame_handle(s_frame_handle),
        .s_guard_ts(s_guard_ts),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_found_handle(m_found_handle),
        .m_found_ts(m_found_ts),
        .m_oldest_ts(m_oldest_ts),
        .m_newest_ts(m_newest_ts),
        .m_held_count(m_held_count),
        .m_end_marked(m_end_marked)
    );

    always #5 aclk = ~aclk;

    // Predictor state: ring of held frames plus flag and span limit
    logic [TS_W-1:0]  win_stamp [WIN_DEPTH];
    logic [HDL_W-1:0] win_handle [WIN_DEPTH];
    logic [5:0]       win_head = '0;
    int               win_count = 0;
    logic             win_ended = 1'b0;
    logic [TS_W-1:0]  span_limit = '0;

    frame_result_t window_results_q [$];
    frame_result_t predicted, expected, got;
    frame_cmd_t    taken_word;
    logic          pin_flag = 1'b0;
    frame_result_t pin_res = '0;
    int            words_in = 0;
    int            words_out = 0;
    int            mismatch_count = 0;
    int            stall_cycles = 0;

    // sender pacing and phase knobs
    int               burst_left = 0;
    logic [TS_W-1:0]  phase_stride = 48'd1000;
    int               clear_pm = 10;

    // receiver pattern
    int rx_mode = 0;
    int rx_left = 0;

    dir_row_t directed_rows [21] = '{
        '{'{tfwc_pkg::CMD_LOOKUP, 48'd0, 16'd0, 48'd0}, 1'b1,
          '{tfwc_pkg::ST_RANGE, 16'd0, 48'd0, 48'd0, 48'd0, 7'd0, 1'b0}},
        '{'{tfwc_pkg::CMD_MARK, 48'd0, 16'd0, 48'd0}, 1'b1,
          '{tfwc_pkg::ST_OK, 16'd0, 48'd0, 48'd0, 48'd0, 7'd0, 1'b1}},
        '{'{tfwc_pkg::CMD_LOOKUP, TS_MAX, 16'd0, 48'd0}, 1'b1,
          '{tfwc_pkg::ST_RANGE, 16'd0, 48'd0, 48'd0, 48'd0, 7'd0, 1'b1}},
        '{'{tfwc_pkg::CMD_APPEND, 48'd0, 16'd0, 48'd0}, 1'b1,
          '{tfwc_pkg::ST_OK, 16'd0, 48'd0, 48'd0, 48'd0, 7'd1, 1'b0}},
        '{'{tfwc_pkg::CMD_APPEND, 48'd0, 16'd5, 48'd0}, 1'b1,
          '{tfwc_pkg::ST_ORDER, 16'd0, 48'd0, 48'd0, 48'd0, 7'd1, 1'b0}},
        '{'{tfwc_pkg::CMD_APPEND, 48'd100, 16'hFFFF, 48'd0}, 1'b1,
          '{tfwc_pkg::ST_OK, 16'd0, 48'd0, 48'd0, 48'd100, 7'd2, 1'b0}},
        '{'{tfwc_pkg::CMD_APPEND, 48'd200, 16'd1, TS_MAX}, 1'b0, '0},
        '{'{tfwc_pkg::CMD_APPEND, 48'd300, 16'd2, 48'd0}, 1'b0, '0},
        '{'{tfwc_pkg::CMD_APPEND, 48'd400, 16'd3, 48'd100}, 1'b0, '0},
        '{'{tfwc_pkg::CMD_LOOKUP, 48'd50, 16'd0, 48'd0}, 1'b1,
          '{tfwc_pkg::ST_RANGE, 16'd0, 48'd0, 48'd100, 48'd400, 7'd4, 1'b0}},
        '{'{tfwc_pkg::CMD_LOOKUP, 48'd250, 16'd0, 48'd0}, 1'b0, '0},
        '{'{tfwc_pkg::CMD_LOOKUP, 48'd400, 16'd0, 48'd0}, 1'b0, '0},
        '{'{tfwc_pkg::CMD_LOOKUP, 48'd500, 16'd0, 48'd0}, 1'b1,
          '{tfwc_pkg::ST_RANGE, 16'd0, 48'd0, 48'd100, 48'd400, 7'd4, 1'b0}},
        '{'{tfwc_pkg::CMD_MARK, 48'd0, 16'd0, 48'd0}, 1'b1,
          '{tfwc_pkg::ST_OK, 16'd0, 48'd0, 48'd100, 48'd400, 7'd4, 1'b1}},
        '{'{tfwc_pkg::CMD_LOOKUP, TS_MAX, 16'd0, 48'd0}, 1'b0, '0},
        '{'{tfwc_pkg::CMD_APPEND, TS_MAX, 16'hFFFF, TS_MAX}, 1'b0, '0},
        '{'{tfwc_pkg::CMD_LOOKUP, TS_MAX, 16'd0, 48'd0}, 1'b0, '0},
        '{'{tfwc_pkg::CMD_CLEAR, 48'd0, 16'd0, 48'd0}, 1'b1,
          '{tfwc_pkg::ST_OK, 16'd0, 48'd0, 48'd0, 48'd0, 7'd0, 1'b0}},
        '{'{tfwc_pkg::CMD_APPEND, TS_MAX, 16'hA5A5, 48'd0}, 1'b1,
          '{tfwc_pkg::ST_OK, 16'd0, 48'd0, TS_MAX, TS_MAX, 7'd1, 1'b0}},
        '{'{tfwc_pkg::CMD_APPEND, 48'd0, 16'd7, 48'd0}, 1'b1,
          '{tfwc_pkg::ST_ORDER, 16'd0, 48'd0, TS_MAX, TS_MAX, 7'd1, 1'b0}},
        '{'{tfwc_pkg::CMD_CLEAR, TS_MAX, 16'hFFFF, TS_MAX}, 1'b0, '0}
    };

    function automatic logic [5:0] ring_slot(int pos);
        return win_head + pos[5:0];
    endfunction

    function automatic logic [TS_W-1:0] stamp_at(int pos);
        return win_stamp[ring_slot(pos)];
    endfunction

    function automatic frame_result_t window_apply(frame_cmd_t w);
        frame_result_t res;
        logic [TS_W-1:0] first;
        logic [TS_W-1:0] last;
        logic evict;
        logic hit;
        logic [5:0] slot;
        res = '0;
        res.status = tfwc_pkg::ST_OK;
        hit = 1'b0;
        case (w.command)
            tfwc_pkg::CMD_APPEND: begin
                if (win_count == 0) begin
                    win_head = '0;
                    win_stamp[0] = w.item_ts;
                    win_handle[0] = w.frame_handle;
                    win_count = 1;
                    win_ended = 1'b0;
                end else begin
                    first = stamp_at(0);
                    last = stamp_at(win_count - 1);
                    if (w.item_ts <= last) begin
                        res.status = tfwc_pkg::ST_ORDER;
                    end else begin
                        // drop the oldest only once the second is no longer needed
                        evict = win_count > tfwc_pkg::EVICT_MIN_HELD &&
                                (last - first) > span_limit &&
                                stamp_at(1) <= w.guard_ts;
                        if (!evict && win_count >= WIN_DEPTH) begin
                            res.status = tfwc_pkg::ST_FULL;
                        end else begin
                            if (evict) begin
                                win_head = win_head + 6'd1;
                                win_count--;
                            end
                            slot = ring_slot(win_count);
                            win_stamp[slot] = w.item_ts;
                            win_handle[slot] = w.frame_handle;
                            win_count++;
                            win_ended = 1'b0;
                        end
                    end
                end
            end
            tfwc_pkg::CMD_LOOKUP: begin
                res.status = tfwc_pkg::ST_RANGE;
                if (win_count != 0 &&
                    !(w.item_ts > stamp_at(win_count - 1) && !win_ended)) begin
                    for (int k = win_count - 1; k >= 0 && !hit; k--) begin
                        if (stamp_at(k) <= w.item_ts) begin
                            hit = 1'b1;
                            res.status = tfwc_pkg::ST_OK;
                            res.found_ts = stamp_at(k);
                            res.found_handle = win_handle[ring_slot(k)];
                        end
                    end
                end
            end
            tfwc_pkg::CMD_CLEAR: begin
                win_head = '0;
                win_count = 0;
                win_ended = 1'b0;
            end
            default: begin
                win_ended = 1'b1;
            end
        endcase
        if (win_count != 0) begin
            res.oldest_ts = stamp_at(0);
            res.newest_ts = stamp_at(win_count - 1);
        end
        res.held_count = CNT_W'(win_count);
        res.end_marked = win_ended;
        return res;
    endfunction

    function automatic logic [TS_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TS_W-1:0];
    endfunction

    function automatic logic [TS_W-1:0] rand_upto(logic [TS_W-1:0] n);
        logic [63:0] v;
        v = {$urandom, $urandom};
        return TS_W'((v % 64'(n)) + 64'd1);
    endfunction

    function automatic logic [TS_W-1:0] pick_held();
        return stamp_at($urandom_range(0, win_count - 1));
    endfunction

    function automatic logic [TS_W-1:0] pick_guard();
        logic [TS_W-1:0] g;
        g = rand48();
        case ($urandom_range(0, 5))
            0: g = '0;
            1: g = TS_MAX;
            2: if (win_count > 0) g = pick_held();
            3: if (win_count > 1) g = stamp_at(1);
            4: if (win_count > 1) g = stamp_at(1) - 48'd1;
            default: ;
        endcase
        return g;
    endfunction

    function automatic logic [TS_W-1:0] pick_query();
        logic [TS_W-1:0] q;
        q = rand48();
        case ($urandom_range(0, 6))
            0: if (win_count > 0) q = pick_held();
            1: if (win_count > 0) q = pick_held() + 48'd1;
            2: if (win_count > 0) q = pick_held() - 48'd1;
            3: if (win_count > 0) q = stamp_at(win_count - 1) + rand_upto(48'd1000);
            4: q = '0;
            5: q = TS_MAX;
            default: ;
        endcase
        return q;
    endfunction

    function automatic frame_cmd_t make_window_word();
        frame_cmd_t w;
        logic [TS_W-1:0] newest;
        int r;
        w.command = tfwc_pkg::CMD_LOOKUP;
        w.item_ts = rand48();
        w.frame_handle = HDL_W'($urandom);
        w.guard_ts = pick_guard();
        r = $urandom_range(0, 999);
        if (r < clear_pm) begin
            w.command = tfwc_pkg::CMD_CLEAR;
        end else if (r < clear_pm + 30) begin
            w.command = tfwc_pkg::CMD_MARK;
        end else if (r < clear_pm + 60) begin
            w.command = tfwc_pkg::CMD_APPEND;
        end else if (r < clear_pm + 140) begin
            // out-of-order append: reuse a held stamp or step just below it
            w.command = tfwc_pkg::CMD_APPEND;
            if (win_count > 0) begin
                w.item_ts = pick_held();
                if ($urandom_range(0, 1) == 1 && w.item_ts != '0)
                    w.item_ts = w.item_ts - 48'd1;
            end
        end else if (r < clear_pm + 480) begin
            w.item_ts = pick_query();
        end else begin
            w.command = tfwc_pkg::CMD_APPEND;
            if (win_count == 0) begin
                case ($urandom_range(0, 7))
                    0, 1, 2, 3: w.item_ts = 48'($urandom_range(0, 1000));
                    4, 5: w.item_ts = rand48();
                    6: w.item_ts = rand48() >> 1;
                    default: w.item_ts = TS_MAX - 48'($urandom_range(0, 5000));
                endcase
            end else begin
                newest = stamp_at(win_count - 1);
                if (newest > TS_MAX - phase_stride)
                    w.command = tfwc_pkg::CMD_CLEAR;
                else
                    w.item_ts = newest + rand_upto(phase_stride);
            end
        end
        return w;
    endfunction

    // Sample both channels at the rising edge; predict on input, check on output
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                taken_word = '{s_command, s_item_ts, s_frame_handle, s_guard_ts};
                predicted = window_apply(taken_word);
                window_results_q.insert(window_results_q.size(),
                                        pin_flag ? pin_res : predicted);
                words_in++;
            end
            if (m_valid && m_ready) begin
                got = '{m_status, m_found_handle, m_found_ts, m_oldest_ts,
                        m_newest_ts, m_held_count, m_end_marked};
                if (window_results_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word %0d: st=%0d cnt=%0d",
                                 words_out, got.status, got.held_count);
                end else begin
                    expected = window_results_q[0];
                    window_results_q.delete(0);
                    if (got.status !== expected.status ||
                        got.found_handle !== expected.found_handle ||
                        got.found_ts !== expected.found_ts ||
                        got.oldest_ts !== expected.oldest_ts ||
                        got.newest_ts !== expected.newest_ts ||
                        got.held_count !== expected.held_count ||
                        got.end_marked !== expected.end_marked) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("result word %0d mismatch", words_out);
                            $display("  got: st=%0d fh=%h fts=%h old=%h new=%h cnt=%0d end=%0d",
                                     got.status, got.found_handle, got.found_ts,
                                     got.oldest_ts, got.newest_ts, got.held_count,
                                     got.end_marked);
                            $display("  exp: st=%0d fh=%h fts=%h old=%h new=%h cnt=%0d end=%0d",
                                     expected.status, expected.found_handle,
                                     expected.found_ts, expected.oldest_ts,
                                     expected.newest_ts, expected.held_count,
                                     expected.end_marked);
                        end
                    end
                end
                words_out++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: runs of always-ready, coin-flip, sparse and long-stall patterns
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(10, 200);
        end
        rx_left--;
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (rx_left % 40) >= 30;
        endcase
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic push_word(frame_cmd_t w, logic pinned, frame_result_t res);
        int sent;
        sent = words_in;
        s_valid <= 1'b1;
        s_command <= w.command;
        s_item_ts <= w.item_ts;
        s_frame_handle <= w.frame_handle;
        s_guard_ts <= w.guard_ts;
        pin_flag <= pinned;
        pin_res <= res;
        do @(negedge aclk); while (words_in == sent);
    endtask

    task automatic hold_sender();
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                    : $urandom_range(1, 20);
        end
        burst_left--;
    endtask

    task automatic drain_window();
        s_valid <= 1'b0;
        do @(negedge aclk); while (window_results_q.size() != 0);
    endtask

    task automatic write_span(logic [TS_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        span_limit = v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [TS_W-1:0] spans [6];
        logic [TS_W-1:0] strides [6];
        int clears [6];
        spans = '{48'd0, TS_MAX, rand48(), 48'd1, 48'($urandom_range(100, 5000)),
                  48'h8000_0000_0000};
        strides = '{48'd1000, 48'd50, 48'hFF_FFFF_FFFF, 48'd3, 48'd200,
                    48'h1000_0000_0000};
        clears = '{10, 2, 5, 5, 5, 20};
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        write_span('0);
        for (int i = 0; i < 21; i++) begin
            hold_sender();
            push_word(directed_rows[i].w, directed_rows[i].pinned, directed_rows[i].res);
        end
        drain_window();
        for (int p = 0; p < 6; p++) begin
            write_span(spans[p]);
            phase_stride = strides[p];
            clear_pm = clears[p];
            for (int i = 0; i < PHASE_WORDS; i++) begin
                hold_sender();
                push_word(make_window_word(), 1'b0, '0);
                if ($urandom_range(0, 249) == 0)
                    drain_window();
            end
            drain_window();
        end
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && window_results_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### timestamp_frame_window_cache.f
src/tfwc_pkg.sv
src/tfwc_ram.sv
src/tfwc_front.sv
src/tfwc_back.sv
src/timestamp_frame_window_cache.sv
src/tfwc_checker.sv
bench/tb_timestamp_frame_window_cache.sv
